// ===== rtl/core/rmts_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmts_pkg
// Shared types and constants for the rate-monotonic task scheduler.
// ----------------------------------------------------------------------------
package rmts_pkg;

	localparam int MAX_TASKS = 16;
	localparam int ID_W     = 22;
	localparam int PER_W    = 16;
	localparam int LOAD_W   = 14;
	localparam int TICK_W   = 32;
	localparam int IDX_W    = $clog2(MAX_TASKS);	// slot index
	localparam int DIVD_W   = 30;	// compute_ms * 10000 fits in 30 bits
	localparam int DCNT_W   = 5;

	localparam logic [LOAD_W-1:0] LOAD_SCALE  = 14'd10000;
	localparam logic [LOAD_W-1:0] BOUND_RESET = 14'd6930;

	typedef enum logic [1:0] {
		MODE_SLEEPING = 2'd1,
		MODE_READY    = 2'd2,
		MODE_RUNNING  = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		REQ_REGISTER   = 2'd0,
		REQ_YIELD      = 2'd1,
		REQ_DEREGISTER = 2'd2,
		REQ_TICK       = 2'd3
	} req_t;

	typedef enum logic [2:0] {
		STAT_OK        = 3'd0,
		STAT_REFUSED   = 3'd1,
		STAT_FULL      = 3'd2,
		STAT_NOT_FOUND = 3'd3,
		STAT_BAD_PER   = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		WR_ADMIT,
		WR_MODE,
		WR_SCHED,
		WR_FREE
	} wr_kind_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIV,
		ST_REG_WAIT,
		ST_REG_END,
		ST_FIND,
		ST_YLD1,
		ST_YLD2,
		ST_DSP_SCAN,
		ST_DSP_A,
		ST_DSP_B,
		ST_DONE
	} state_t;

	// packet walked down the slot chain, one cell per cycle
	typedef struct packed {
		logic                valid;
		logic                wake;
		logic [ID_W-1:0]     match_id;
		logic [TICK_W-1:0]   tick;
		logic [IDX_W-1:0]    act_idx;
		logic                free_found;
		logic [IDX_W-1:0]    free_idx;
		logic                id_found;
		logic [IDX_W-1:0]    id_idx;
		logic [PER_W-1:0]    id_period;
		logic [TICK_W-1:0]   id_deadline;
		logic                id_hasdl;
		logic [LOAD_W-1:0]   id_load;
		logic                best_found;
		logic [IDX_W-1:0]    best_idx;
		logic [PER_W-1:0]    best_period;
		logic [ID_W-1:0]     best_id;
		mode_t               act_mode;
		logic [PER_W-1:0]    act_period;
	} scan_t;

	// broadcast write into one slot
	typedef struct packed {
		logic                en;
		wr_kind_t            kind;
		logic [IDX_W-1:0]    idx;
		logic [ID_W-1:0]     ident;
		logic [PER_W-1:0]    period;
		logic [LOAD_W-1:0]   load;
		mode_t               mode;
		logic [TICK_W-1:0]   deadline;
	} wr_t;

endpackage

// ===== rtl/core/rmts_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmts_cell
// One task slot; updates the passing scan packet and registers it onward.
// ----------------------------------------------------------------------------
module rmts_cell import rmts_pkg::*; #(
	parameter logic [IDX_W-1:0] IDX = '0
) (
	input  logic  clk,
	input  logic  arst_n,
	input  scan_t scan_in,
	input  wr_t   wr,
	output scan_t scan_out
);

	logic              used_q;
	logic [ID_W-1:0]   ident_q;
	logic [PER_W-1:0]  period_q;
	logic [LOAD_W-1:0] load_q;
	mode_t             mode_q;
	logic [TICK_W-1:0] dl_q;
	logic              hasdl_q;

	logic  wake_now;
	mode_t mode_eff;
	logic  hit;
	scan_t nxt;
	scan_t data_q;
	logic  valid_q;

	assign hit = wr.en && (wr.idx == IDX);
	assign wake_now = scan_in.wake && used_q && (mode_q == MODE_SLEEPING) && hasdl_q &&
		(dl_q <= scan_in.tick);
	assign mode_eff = wake_now ? MODE_READY : mode_q;

	always_comb begin
		nxt = scan_in;
		if (!used_q && !scan_in.free_found) begin
			nxt.free_found = 1'b1;
			nxt.free_idx   = IDX;
		end
		if (used_q && !scan_in.id_found && (ident_q == scan_in.match_id)) begin
			nxt.id_found    = 1'b1;
			nxt.id_idx      = IDX;
			nxt.id_period   = period_q;
			nxt.id_deadline = dl_q;
			nxt.id_hasdl    = hasdl_q;
			nxt.id_load     = load_q;
		end
		// strict compare keeps the lowest slot on ties
		if (used_q && (mode_eff == MODE_READY) &&
				(!scan_in.best_found || (period_q < scan_in.best_period))) begin
			nxt.best_found  = 1'b1;
			nxt.best_idx    = IDX;
			nxt.best_period = period_q;
			nxt.best_id     = ident_q;
		end
		if (used_q && (scan_in.act_idx == IDX)) begin
			nxt.act_mode   = mode_eff;
			nxt.act_period = period_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q  <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			valid_q <= scan_in.valid;
			if (hit && (wr.kind == WR_ADMIT))
				used_q <= 1'b1;
			else if (hit && (wr.kind == WR_FREE))
				used_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		data_q <= nxt;

		if (hit) begin
			case (wr.kind)
				WR_ADMIT: begin
					ident_q  <= wr.ident;
					period_q <= wr.period;
					load_q   <= wr.load;
					mode_q   <= MODE_SLEEPING;
					dl_q     <= '0;
					hasdl_q  <= 1'b0;
				end
				WR_MODE: mode_q <= wr.mode;
				WR_SCHED: begin
					mode_q  <= wr.mode;
					dl_q    <= wr.deadline;
					hasdl_q <= 1'b1;
				end
				default: ;
			endcase
		end else if (scan_in.valid && wake_now) begin
			mode_q <= MODE_READY;
		end
	end

	always_comb begin
		scan_out       = data_q;
		scan_out.valid = valid_q;
	end

endmodule

// ===== rtl/core/rmts_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmts_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rmts_div import rmts_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DIVD_W-1:0] dividend,
	input  logic [PER_W-1:0]  divisor,
	output logic              done,
	output logic [DIVD_W-1:0] quotient
);

	logic              busy_q;
	logic              done_q;
	logic [DCNT_W-1:0] cnt_q;
	logic [PER_W:0]    rem_q;
	logic [DIVD_W-1:0] quo_q;
	logic [PER_W-1:0]  dvs_q;

	logic [PER_W:0] rem_sh;
	logic [PER_W:0] diff;
	logic           ge;

	assign rem_sh = {rem_q[PER_W-1:0], quo_q[DIVD_W-1]};
	assign ge     = rem_sh >= {1'b0, dvs_q};
	assign diff   = rem_sh - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == DCNT_W'(DIVD_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DIVD_W-2:0], ge};
			rem_q <= ge ? diff : rem_sh;
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ===== rtl/core/rate_monotonic_task_scheduler.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rate_monotonic_task_scheduler
// Periodic task table with admission control and shortest-period dispatch.
// ----------------------------------------------------------------------------
// Requests are handled one at a time. Every slot lookup walks a packet down
// the chain of MAX_TASKS slot cells, one cell per cycle, and the result is
// registered at the chain end. A register waits for both the serial divider
// and the walk, which run side by side; a zero-period register skips both. A
// yield and a deregister of the running task each take two walks, any other
// deregister, an unknown id or a tick one. The next request is accepted in the
// cycle after the one that loads the response. A finished result waits in the
// output register while the next request is taken; if it is still waiting when
// the next one is done, the block holds until the receiver takes it.
module rate_monotonic_task_scheduler import rmts_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [1:0]  s_tuser,	// req_type
	input  logic [55:0] s_tdata,	// task_id, period_ms, compute_ms, zero pad
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,	// status, running_valid, running_id, switched,
					// load_sum, zero pad
	input  logic        cfg_we,
	input  logic [13:0] cfg_wdata
);

	state_t state_q, state_d;

	logic [LOAD_W-1:0] bound_q;
	logic [LOAD_W-1:0] total_q;
	logic [TICK_W-1:0] tick_q;
	logic              av_q;
	logic [IDX_W-1:0]  act_q;
	logic [ID_W-1:0]   act_id_q;
	logic              was_av_q;
	logic [IDX_W-1:0]  was_act_q;

	req_t              req_q;
	logic [ID_W-1:0]   id_q;
	logic [PER_W-1:0]  per_q;
	logic [PER_W-1:0]  cmp_q;
	status_t           stat_q;
	scan_t             res_q;
	logic              res_ok_q;
	logic [TICK_W-1:0] next_q;

	logic              m_valid_q;
	logic [47:0]       m_data_q;

	logic              launch, launch_q, wake_q;
	wr_t               wr;
	scan_t             chain [MAX_TASKS+1];
	scan_t             head;

	logic              div_start, div_done;
	logic [DIVD_W-1:0] div_q;
	logic [DIVD_W-1:0] dividend;
	logic [DIVD_W:0]   sum;
	logic              out_free;
	logic              sw;

	assign out_free  = !m_valid_q || m_tready;
	assign s_tready  = (state_q == ST_IDLE);
	assign div_start = (state_q == ST_DIV);
	assign dividend  = DIVD_W'({14'd0, cmp_q} * {16'd0, LOAD_SCALE});
	assign sum       = {(DIVD_W + 1 - LOAD_W)'(0), total_q} + {1'b0, div_q};

	rmts_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(dividend),
		.divisor(per_q), .done(div_done), .quotient(div_q)
	);

	always_comb begin
		head          = '0;
		head.valid    = launch_q;
		head.wake     = wake_q;
		head.match_id = id_q;
		head.tick     = tick_q;
		head.act_idx  = act_q;
	end
	assign chain[0] = head;

	genvar g;
	generate
		for (g = 0; g < MAX_TASKS; g++) begin : g_cell
			rmts_cell #(.IDX(IDX_W'(g))) u_cell (
				.clk(clk), .arst_n(arst_n), .scan_in(chain[g]), .wr(wr),
				.scan_out(chain[g+1])
			);
		end
	endgenerate

	always_comb begin
		state_d     = state_q;
		launch      = 1'b0;
		wr          = '0;
		wr.kind     = WR_MODE;
		wr.ident    = id_q;
		wr.period   = per_q;
		wr.load     = div_q[LOAD_W-1:0];
		wr.mode     = MODE_READY;
		wr.deadline = next_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					case (req_t'(s_tuser))
						REQ_REGISTER: begin
							if (s_tdata[37:22] == '0) begin
								state_d = ST_DONE;
							end else begin
								state_d = ST_DIV;
								launch  = 1'b1;
							end
						end
						REQ_TICK: begin
							state_d = ST_DSP_SCAN;
							launch  = 1'b1;
						end
						default: begin
							state_d = ST_FIND;
							launch  = 1'b1;
						end
					endcase
				end
			end
			ST_DIV: state_d = ST_REG_WAIT;
			ST_REG_WAIT: begin
				if (div_done && res_ok_q)
					state_d = ST_REG_END;
			end
			ST_REG_END: begin
				wr.kind = WR_ADMIT;
				wr.idx  = res_q.free_idx;
				wr.en   = res_q.free_found && (sum <= {17'd0, bound_q});
				state_d = ST_DONE;
			end
			ST_FIND: begin
				if (res_ok_q) begin
					if (!res_q.id_found) begin
						state_d = ST_DONE;
					end else if (req_q == REQ_YIELD) begin
						state_d = ST_YLD1;
					end else begin
						wr.en   = 1'b1;
						wr.kind = WR_FREE;
						wr.idx  = res_q.id_idx;
						if (av_q && (act_q == res_q.id_idx)) begin
							state_d = ST_DSP_SCAN;
							launch  = 1'b1;
						end else begin
							state_d = ST_DONE;
						end
					end
				end
			end
			ST_YLD1: state_d = ST_YLD2;
			ST_YLD2: begin
				wr.en   = 1'b1;
				wr.kind = WR_SCHED;
				wr.idx  = res_q.id_idx;
				if (res_q.id_hasdl && (next_q < tick_q)) begin
					wr.deadline = next_q + {16'd0, res_q.id_period};
					wr.mode     = MODE_READY;
				end else begin
					wr.mode     = MODE_SLEEPING;
				end
				state_d = ST_DSP_SCAN;
				launch  = 1'b1;
			end
			ST_DSP_SCAN: begin
				if (res_ok_q) begin
					if (!res_q.best_found)
						state_d = ST_DONE;
					else if (av_q && (res_q.act_mode == MODE_RUNNING))
						state_d = (res_q.act_period > res_q.best_period) ? ST_DSP_A : ST_DONE;
					else
						state_d = ST_DSP_B;
				end
			end
			ST_DSP_A: begin
				wr.en   = 1'b1;
				wr.idx  = act_q;
				wr.mode = MODE_READY;
				state_d = ST_DSP_B;
			end
			ST_DSP_B: begin
				wr.en   = 1'b1;
				wr.idx  = res_q.best_idx;
				wr.mode = MODE_RUNNING;
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_free)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign sw = (was_av_q != av_q) || (was_av_q && av_q && (was_act_q != act_q)) ||
		((req_q == REQ_DEREGISTER) && (stat_q == STAT_OK) && was_av_q && !av_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			bound_q   <= BOUND_RESET;
			total_q   <= '0;
			tick_q    <= '0;
			av_q      <= 1'b0;
			act_q     <= '0;
			launch_q  <= 1'b0;
			res_ok_q  <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			launch_q <= launch;
			if (cfg_we)
				bound_q <= cfg_wdata;
			if (launch)
				res_ok_q <= 1'b0;
			else if (chain[MAX_TASKS].valid)
				res_ok_q <= 1'b1;
			if ((state_q == ST_DONE) && out_free)
				m_valid_q <= 1'b1;
			else if (m_tready)
				m_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid && (req_t'(s_tuser) == REQ_TICK))
						tick_q <= tick_q + 1'b1;
				end
				ST_REG_END: begin
					if (wr.en)
						total_q <= sum[LOAD_W-1:0];
				end
				ST_FIND: begin
					if (wr.en) begin
						total_q <= (total_q >= res_q.id_load) ? (total_q - res_q.id_load) : '0;
						if (av_q && (act_q == res_q.id_idx))
							av_q <= 1'b0;
					end
				end
				ST_DSP_SCAN: begin
					if (res_ok_q && !res_q.best_found && av_q &&
							(res_q.act_mode != MODE_RUNNING))
						av_q <= 1'b0;
				end
				ST_DSP_B: begin
					av_q  <= 1'b1;
					act_q <= res_q.best_idx;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (chain[MAX_TASKS].valid)
			res_q <= chain[MAX_TASKS];
		if (launch)
			wake_q <= (state_q == ST_IDLE) && (req_t'(s_tuser) == REQ_TICK);
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					req_q     <= req_t'(s_tuser);
					id_q      <= s_tdata[21:0];
					per_q     <= s_tdata[37:22];
					cmp_q     <= s_tdata[53:38];
					was_av_q  <= av_q;
					was_act_q <= act_q;
					stat_q    <= (req_t'(s_tuser) == REQ_REGISTER) && (s_tdata[37:22] == '0) ?
						STAT_BAD_PER : STAT_OK;
				end
			end
			ST_REG_END: begin
				if (!res_q.free_found)
					stat_q <= STAT_FULL;
				else if (sum > {17'd0, bound_q})
					stat_q <= STAT_REFUSED;
			end
			ST_FIND: begin
				if (res_ok_q && !res_q.id_found)
					stat_q <= STAT_NOT_FOUND;
			end
			ST_YLD1: begin
				next_q <= (res_q.id_hasdl ? res_q.id_deadline : tick_q) +
					{16'd0, res_q.id_period};
			end
			ST_DSP_B: act_id_q <= res_q.best_id;
			ST_DONE: begin
				if (out_free)
					m_data_q <= {7'd0, total_q, sw, (av_q ? act_id_q : 22'd0), av_q, stat_q};
			end
			default: ;
		endcase
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

endmodule

// ===== rtl/core/rmts_chk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmts_chk
// Port-level checks for the rate-monotonic task scheduler.
// ----------------------------------------------------------------------------
module rmts_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [47:0] m_tdata
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result dropped or changed while stalled");

	a_idle_id: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[3] |-> (m_tdata[25:4] == 22'd0))
		else $error("running id set with no running task");

	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[2:0] <= 3'd4))
		else $error("status code out of range");

	a_err_nosw: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[2:0] != 3'd0) |-> !m_tdata[26])
		else $error("failed request switched tasks");

endmodule

bind rate_monotonic_task_scheduler rmts_chk u_rmts_chk (
	.clk(clk), .arst_n(arst_n), .m_tvalid(m_tvalid), .m_tready(m_tready),
	.m_tdata(m_tdata)
);

// ===== tb/sv/tb_rate_monotonic_task_scheduler.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rate_monotonic_task_scheduler
// Self-checking bench for the rate-monotonic task scheduler. Requests are
// driven over the input stream with random gaps. A local model of the task
// table predicts status, running task, switch flag and load sum for each
// response, and every response is compared against that prediction.
// ----------------------------------------------------------------------------
module tb_rate_monotonic_task_scheduler;
	import rmts_pkg::*;

	localparam int NSLOT = MAX_TASKS;
	localparam int WDOG_LIMIT = 20000;
	localparam int RX_HOLD = 600;

	typedef struct packed {
		status_t          status;
		logic             run_valid;
		logic [ID_W-1:0]  run_id;
		logic             switched;
		logic [LOAD_W-1:0] load;
	} sched_resp_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [1:0]  s_tuser = '0;
	logic [55:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [47:0] m_tdata;
	logic        cfg_we = 1'b0;
	logic [13:0] cfg_wdata = '0;

	rate_monotonic_task_scheduler u_top (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tuser(s_tuser), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	always #4 clk = ~clk;

	// scheduler shadow state
	logic [LOAD_W-1:0] bound_q;
	logic              used_q[NSLOT];
	logic [ID_W-1:0]   ident_q[NSLOT];
	logic [PER_W-1:0]  period_q[NSLOT];
	logic [LOAD_W-1:0] slot_load_q[NSLOT];
	mode_t             mode_q[NSLOT];
	logic [31:0]       deadline_q[NSLOT];
	logic              hasdl_q[NSLOT];
	logic [LOAD_W-1:0] total_q;
	logic [31:0]       ticks_q;
	logic              act_valid_q;
	int                act_slot_q;

	sched_resp_t expected_resps[$];
	logic [ID_W-1:0] known_ids[$];
	int errors = 0;
	int resp_count = 0;
	int req_count = 0;
	int idle_cycles = 0;
	bit hold_rx = 0;

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] exp);
		errors++;
		$display("mismatch #%0d response %0d %s: got %0h expected %0h",
			errors, resp_count, what, got, exp);
	endtask

	function automatic void model_reset();
		bound_q = BOUND_RESET;
		for (int i = 0; i < NSLOT; i++) used_q[i] = 0;
		total_q = '0;
		ticks_q = '0;
		act_valid_q = 0;
		act_slot_q = 0;
	endfunction

	function automatic int lookup(input logic [ID_W-1:0] id);
		for (int i = 0; i < NSLOT; i++)
			if (used_q[i] && ident_q[i] == id) return i;
		return -1;
	endfunction

	function automatic void pick_running();
		int best;
		best = -1;
		for (int i = 0; i < NSLOT; i++)
			if (used_q[i] && mode_q[i] == MODE_READY)
				if (best < 0 || period_q[i] < period_q[best]) best = i;
		if (best < 0) begin
			if (act_valid_q && mode_q[act_slot_q] != MODE_RUNNING) act_valid_q = 0;
			return;
		end
		if (act_valid_q && mode_q[act_slot_q] == MODE_RUNNING) begin
			if (period_q[act_slot_q] > period_q[best]) begin
				mode_q[act_slot_q] = MODE_READY;
				mode_q[best] = MODE_RUNNING;
				act_slot_q = best;
			end
		end else begin
			mode_q[best] = MODE_RUNNING;
			act_slot_q = best;
			act_valid_q = 1;
		end
	endfunction

	function automatic sched_resp_t predict(input req_t req, input logic [ID_W-1:0] id,
			input logic [PER_W-1:0] per, input logic [PER_W-1:0] comp);
		sched_resp_t r;
		status_t st;
		logic was_valid;
		int was_slot, s, fs;
		logic [63:0] ld, sum;
		logic [31:0] nxt;
		was_valid = act_valid_q;
		was_slot = act_slot_q;
		st = STAT_OK;
		case (req)
			REQ_REGISTER: begin
				fs = -1;
				for (int i = NSLOT - 1; i >= 0; i--) if (!used_q[i]) fs = i;
				if (per == 0) st = STAT_BAD_PER;
				else if (fs < 0) st = STAT_FULL;
				else begin
					ld = (64'(comp) * 64'd10000) / 64'(per);
					sum = 64'(total_q) + ld;
					if (sum > 64'(bound_q)) st = STAT_REFUSED;
					else begin
						used_q[fs] = 1;
						ident_q[fs] = id;
						period_q[fs] = per;
						slot_load_q[fs] = ld[LOAD_W-1:0];
						mode_q[fs] = MODE_SLEEPING;
						deadline_q[fs] = '0;
						hasdl_q[fs] = 0;
						total_q = sum[LOAD_W-1:0];
					end
				end
			end
			REQ_YIELD: begin
				s = lookup(id);
				if (s < 0) st = STAT_NOT_FOUND;
				else begin
					if (!hasdl_q[s]) begin
						deadline_q[s] = ticks_q + 32'(period_q[s]);
						mode_q[s] = MODE_SLEEPING;
					end else begin
						nxt = deadline_q[s] + 32'(period_q[s]);
						if (nxt < ticks_q) begin
							deadline_q[s] = nxt + 32'(period_q[s]);
							mode_q[s] = MODE_READY;
						end else begin
							deadline_q[s] = nxt;
							mode_q[s] = MODE_SLEEPING;
						end
					end
					hasdl_q[s] = 1;
					pick_running();
				end
			end
			REQ_DEREGISTER: begin
				s = lookup(id);
				if (s < 0) st = STAT_NOT_FOUND;
				else begin
					used_q[s] = 0;
					total_q = (total_q >= slot_load_q[s]) ? total_q - slot_load_q[s] : '0;
					if (act_valid_q && act_slot_q == s) begin
						act_valid_q = 0;
						pick_running();
					end
				end
			end
			default: begin
				ticks_q++;
				for (int i = 0; i < NSLOT; i++)
					if (used_q[i] && mode_q[i] == MODE_SLEEPING && hasdl_q[i] &&
							deadline_q[i] <= ticks_q)
						mode_q[i] = MODE_READY;
				pick_running();
			end
		endcase
		r.status = st;
		r.run_valid = act_valid_q;
		r.run_id = act_valid_q ? ident_q[act_slot_q] : '0;
		r.switched = (was_valid != act_valid_q) ||
			(was_valid && act_valid_q && was_slot != act_slot_q) ||
			(req == REQ_DEREGISTER && st == STAT_OK && was_valid && !act_valid_q);
		r.load = total_q;
		return r;
	endfunction

	// leaves s_tvalid high; a gap before the next request, or wait_drained, drops it
	task automatic send_request(input req_t req, input logic [ID_W-1:0] id,
			input logic [PER_W-1:0] per, input logic [PER_W-1:0] comp);
		int gap;
		gap = $urandom_range(0, 3);
		if ($urandom_range(0, 3) == 0) gap = 0;
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= req;
		s_tdata <= {8'd0, comp, per, id};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		expected_resps.push_back(predict(req, id, per, comp));
		req_count++;
		@(negedge clk);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (expected_resps.size() != 0) @(negedge clk);
		repeat (60) @(negedge clk);
	endtask

	task automatic write_bound(input logic [13:0] v);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		bound_q = v;
	endtask

	function automatic logic [ID_W-1:0] pick_id();
		if (known_ids.size() != 0 && $urandom_range(0, 9) < 8)
			return known_ids[$urandom_range(0, known_ids.size() - 1)];
		return ID_W'($urandom);
	endfunction

	task automatic admit_task(input logic [ID_W-1:0] id, input logic [PER_W-1:0] per,
			input logic [PER_W-1:0] comp);
		known_ids.push_back(id);
		if (known_ids.size() > 40) void'(known_ids.pop_front());
		send_request(REQ_REGISTER, id, per, comp);
	endtask

	// extremes of fields, every request kind, error statuses
	task automatic test_directed();
		send_request(REQ_YIELD, 22'h3FFFFF, 16'hFFFF, 16'hFFFF);	// unknown id
		send_request(REQ_DEREGISTER, 22'd0, 16'd0, 16'd0);
		send_request(REQ_REGISTER, 22'd5, 16'd0, 16'd1);		// zero period
		admit_task(22'd0, 16'hFFFF, 16'd0);
		admit_task(22'h3FFFFF, 16'd1, 16'd0);
		admit_task(22'd7, 16'd1, 16'hFFFF);				// refused
		admit_task(22'd7, 16'd10, 16'd3);
		admit_task(22'd7, 16'd4, 16'd1);				// duplicate id
		send_request(REQ_YIELD, 22'd7, 16'd0, 16'd0);
		send_request(REQ_YIELD, 22'h3FFFFF, 16'd0, 16'd0);
		repeat (3) send_request(REQ_TICK, 22'h2AAAAA, 16'hAAAA, 16'h5555);
		send_request(REQ_YIELD, 22'h3FFFFF, 16'd0, 16'd0);
		send_request(REQ_DEREGISTER, 22'h3FFFFF, 16'd0, 16'd0);
		for (int i = 0; i < 14; i++) admit_task(22'(100 + i), 16'(50 + i), 16'd0);
		admit_task(22'd999, 16'd9, 16'd0);				// table full
		send_request(REQ_DEREGISTER, 22'd7, 16'd0, 16'd0);
		send_request(REQ_TICK, 22'h155555, 16'h5555, 16'hAAAA);
	endtask

	task automatic test_random(input int n);
		int k;
		for (int i = 0; i < n; i++) begin
			k = $urandom_range(0, 99);
			if (k < 20)
				admit_task(pick_id(), ($urandom_range(0, 7) == 0) ? 16'($urandom) :
					16'($urandom_range(0, 40)), ($urandom_range(0, 9) == 0) ?
					16'($urandom) : 16'($urandom_range(0, 8)));
			else if (k < 50) send_request(REQ_YIELD, pick_id(), 16'($urandom), 16'($urandom));
			else if (k < 60) send_request(REQ_DEREGISTER, pick_id(), 16'($urandom),
				16'($urandom));
			else send_request(REQ_TICK, ID_W'($urandom), 16'($urandom), 16'($urandom));
		end
	endtask

	// receiver holds off while requests keep coming, block must back up
	task automatic test_backpressure();
		hold_rx = 1;
		test_random(12);
	endtask

	// response side
	always @(posedge clk) begin
		sched_resp_t got, exp;
		if (m_tvalid && m_tready) begin
			got = {m_tdata[2:0], m_tdata[3], m_tdata[25:4], m_tdata[26], m_tdata[40:27]};
			if (expected_resps.size() == 0) report("unexpected response", m_tdata[31:0], 0);
			else begin
				exp = expected_resps.pop_front();
				if (got.status != exp.status) report("status", got.status, exp.status);
				if (got.run_valid != exp.run_valid)
					report("running_valid", got.run_valid, exp.run_valid);
				if (got.run_id != exp.run_id) report("running_id", got.run_id, exp.run_id);
				if (got.switched != exp.switched)
					report("switched", got.switched, exp.switched);
				if (got.load != exp.load) report("load_sum", got.load, exp.load);
			end
			resp_count++;
		end
	end

	// receiver: per response a random wait before ready, or one long hold
	always begin : rx_side
		int rx_wait;
		rx_wait = $urandom_range(0, 3);
		if (hold_rx) begin
			m_tready <= 1'b0;
			repeat (RX_HOLD) @(negedge clk);
			hold_rx = 0;
		end else if (rx_wait != 0) begin
			m_tready <= 1'b0;
			repeat (rx_wait) @(negedge clk);
		end
		m_tready <= 1'b1;
		@(posedge clk);
		while (!(m_tvalid && m_tready)) @(posedge clk);
		@(negedge clk);
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) idle_cycles = 0;
		else idle_cycles++;
		if (idle_cycles >= WDOG_LIMIT) begin
			$display("watchdog expired after %0d idle cycles", idle_cycles);
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		model_reset();
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed();
		wait_drained();
		write_bound(14'd10000);
		test_random(450);
		test_backpressure();
		wait_drained();
		write_bound(14'd0);
		test_random(150);
		wait_drained();
		write_bound(14'h3FFF);
		test_random(350);
		wait_drained();
		write_bound(14'($urandom_range(0, 10000)));
		test_random(320);
		wait_drained();
		$display("covered %0d requests, %0d responses checked, bound settings 0 to max",
			req_count, resp_count);
		if (errors == 0) $display("TB_OK");
		else $display("TB_ERROR");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/core/rmts_pkg.sv
rtl/core/rmts_cell.sv
rtl/core/rmts_div.sv
rtl/core/rate_monotonic_task_scheduler.sv
rtl/core/rmts_chk.sv
tb/sv/tb_rate_monotonic_task_scheduler.sv
